[hw/rtl/sla_pkg.sv]
// Shared types, codes, colors and pattern tables of the status LED animator.
// No dependencies; the top level takes it by wildcard import.
package sla_pkg;

    typedef logic [23:0] t_rgb;
    typedef logic [31:0][5:0] t_wrap_tbl;

    // Strip size default and the span of the ring patterns.
    localparam int LED_COUNT_DEF = 24;
    localparam int RING_SPAN = 24;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_FLASH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LAYOUT = 2'd3;

    localparam logic [9:0] FRAME_INTERVAL_RST = 10'd20;
    localparam logic [15:0] TRIGGER_LENGTH_RST = 16'd2000;
    localparam logic [15:0] ERROR_FLASH_RST = 16'd250;

    // Input function codes.
    localparam logic [2:0] FUNC_TICK = 3'd0;
    localparam logic [2:0] FUNC_SET_MODE = 3'd1;
    localparam logic [2:0] FUNC_SUCCESS = 3'd2;
    localparam logic [2:0] FUNC_ERROR = 3'd3;
    localparam logic [2:0] FUNC_INDICATE = 3'd4;

    // Display modes.
    localparam logic [2:0] MODE_CONFIG = 3'd0;
    localparam logic [2:0] MODE_INIT = 3'd1;
    localparam logic [2:0] MODE_WAIT_CARD = 3'd2;
    localparam logic [2:0] MODE_AUTH = 3'd3;
    localparam logic [2:0] MODE_NO_RES = 3'd4;
    localparam logic [2:0] MODE_FW_UPDATE = 3'd5;

    // Active trigger codes.
    localparam logic [1:0] TRIG_NONE = 2'd0;
    localparam logic [1:0] TRIG_SUCCESS = 2'd1;
    localparam logic [1:0] TRIG_ERROR = 2'd2;
    localparam logic [1:0] TRIG_INDICATE = 2'd3;

    // Error flashing runs for this many on and off phases.
    localparam logic [2:0] ERR_PHASES = 3'd6;
    // Indicate blinking steps, in milliseconds within a 400 ms period.
    localparam logic [8:0] IND_STEP_1 = 9'd100;
    localparam logic [8:0] IND_STEP_2 = 9'd200;
    localparam logic [8:0] IND_STEP_3 = 9'd300;
    localparam logic [8:0] IND_PERIOD_LAST = 9'd399;

    // Colors.
    localparam t_rgb RGB_OFF = 24'h000000;
    localparam t_rgb RGB_ORANGE = {8'd255, 8'd165, 8'd0};
    localparam t_rgb RGB_BLUE = {8'd0, 8'd0, 8'd255};
    localparam t_rgb RGB_GREEN = {8'd0, 8'd255, 8'd0};
    localparam t_rgb RGB_CYAN = {8'd100, 8'd200, 8'd255};
    localparam t_rgb RGB_RED = {8'd255, 8'd0, 8'd0};
    localparam t_rgb RGB_YELLOW = {8'd255, 8'd255, 8'd0};

    // Scale every channel by f/255, rounding down. Used only to build tables.
    function automatic t_rgb dim(input t_rgb c, input int f);
        int r;
        int g;
        int b;
        r = int'(c[23:16]) * f / 255;
        g = int'(c[15:8]) * f / 255;
        b = int'(c[7:0]) * f / 255;
        return {8'(r), 8'(g), 8'(b)};
    endfunction

    // Color of a linear breathing mode at a position within its period.
    function automatic t_rgb lin_color(input int m, input int p);
        int b;
        t_rgb c;
        b = 0;
        c = RGB_OFF;
        if (m == 0) begin
            b = (p < 20) ? 64 + 64 * p / 20 : 128 - 64 * (p - 20) / 20;
            c = RGB_ORANGE;
        end else if (m == 1) begin
            b = (p < 15) ? 32 + 96 * p / 15 : 128 - 96 * (p - 15) / 15;
            c = RGB_BLUE;
        end else if (m == 2) begin
            b = (p < 13) ? 48 + 48 * p / 13 : 96 - 48 * (p - 13) / 12;
            c = RGB_GREEN;
        end else begin
            b = (p < 5) ? 80 + 80 * p / 5 : 160 - 80 * (p - 5) / 5;
            c = RGB_CYAN;
        end
        return dim(c, b);
    endfunction

    function automatic logic [39:0][23:0] lin0_table();
        logic [39:0][23:0] t;
        for (int p = 0; p < 40; p++) begin
            t[p] = lin_color(0, p);
        end
        return t;
    endfunction

    function automatic logic [29:0][23:0] lin1_table();
        logic [29:0][23:0] t;
        for (int p = 0; p < 30; p++) begin
            t[p] = lin_color(1, p);
        end
        return t;
    endfunction

    function automatic logic [24:0][23:0] lin2_table();
        logic [24:0][23:0] t;
        for (int p = 0; p < 25; p++) begin
            t[p] = lin_color(2, p);
        end
        return t;
    endfunction

    function automatic logic [9:0][23:0] lin3_table();
        logic [9:0][23:0] t;
        for (int p = 0; p < 10; p++) begin
            t[p] = lin_color(3, p);
        end
        return t;
    endfunction

    localparam logic [39:0][23:0] LIN0_TBL = lin0_table();
    localparam logic [29:0][23:0] LIN1_TBL = lin1_table();
    localparam logic [24:0][23:0] LIN2_TBL = lin2_table();
    localparam logic [9:0][23:0] LIN3_TBL = lin3_table();

    // Ring position reduced onto a strip of n pixels, counted up without division.
    function automatic t_wrap_tbl wrap_table(input int n);
        t_wrap_tbl t;
        int c;
        c = 0;
        for (int v = 0; v < 32; v++) begin
            t[v] = 6'(c);
            c = c + 1;
            if (c == n) begin
                c = 0;
            end
        end
        return t;
    endfunction

    // Blue level of comet segment k: 255 - 42k for k up to 5, and 0 beyond.
    function automatic logic [7:0] comet_blue(input logic [2:0] k);
        logic [7:0] v;
        unique case (k)
            3'd0: v = 8'd255;
            3'd1: v = 8'd213;
            3'd2: v = 8'd171;
            3'd3: v = 8'd129;
            3'd4: v = 8'd87;
            3'd5: v = 8'd45;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/sla_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies beyond its parameters.
module sla_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; the read data holds while not read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hw/rtl/status_led_animator.sv]
// Status LED animator: a tick that opens a frame emits LED_COUNT pixel transactions
// (none in firmware-update mode with no trigger) after the frame state and, as needed, the
// setup state or the flash search (one compare-and-add per cycle); pixels then go out one
// per cycle while the output does not stall, as the pixel RAM port is swept. Other items
// stay in the idle state. Reset clears all control state, counters and the per-pixel
// valid flags, so the strip reads as off at once; there is no clearing pass.
module status_led_animator #(
    parameter int LED_COUNT = sla_pkg::LED_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [sla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_func,
    input  logic [2:0]                     i_new_mode,
    // Output channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [5:0]                     o_pixel_index,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic                           o_frame_end
);

    import sla_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_PIX = IDX_W'(LED_COUNT - 1);
    localparam t_wrap_tbl WRAP_TBL = wrap_table(LED_COUNT);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FRAME = 3'd1;
    localparam logic [2:0] ST_ERR = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // How the pixels of the current frame are formed.
    localparam logic [2:0] KIND_FILL = 3'd0;
    localparam logic [2:0] KIND_KEEP = 3'd1;
    localparam logic [2:0] KIND_DOT = 3'd2;
    localparam logic [2:0] KIND_HALF = 3'd3;
    localparam logic [2:0] KIND_COMET = 3'd4;
    localparam logic [2:0] KIND_ARC = 3'd5;

    // Configuration registers.
    logic [9:0]  r_frame_interval;
    logic [15:0] r_trigger_length;
    logic [15:0] r_error_flash;
    logic        r_ring_layout;

    // Control and timing state.
    logic [2:0]  r_state;
    logic [31:0] r_since;
    logic [31:0] r_elapsed;
    logic [8:0]  r_m400;
    logic [1:0]  r_active;
    logic [2:0]  r_saved_mode;
    logic [2:0]  r_display_mode;
    logic [31:0] r_phase;
    logic [5:0]  r_p48;
    logic [5:0]  r_p40;
    logic [4:0]  r_p30;
    logic [4:0]  r_p25;
    logic [3:0]  r_p10;

    // Error flash phase search.
    logic [18:0] r_acc;
    logic [2:0]  r_cnt;

    // Per-frame rendering parameters.
    logic [2:0]       r_kind;
    t_rgb             r_fill;
    logic [4:0]       r_dot_pos;
    t_rgb             r_dot_col;
    logic [3:0]       r_len;
    logic [IDX_W-1:0] r_pos [8];
    logic [IDX_W-1:0] r_pix;

    // Pixel valid flags and pipeline.
    logic [LED_COUNT-1:0] r_valid;
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    t_rgb             r_s1_color;
    logic             r_s1_keep;
    logic             r_s1_vld;
    logic             r_s1_last;
    logic             r_out_valid;
    logic [5:0]       r_out_idx;
    t_rgb             r_out_color;
    logic             r_out_last;

    logic        accept;
    logic [31:0] n_since;
    logic        due;
    logic [15:0] flash;
    logic        ind_on;
    logic [5:0]  p24;
    logic [5:0]  p12;
    logic [5:0]  p20;
    logic [4:0]  start;
    logic        out_free;
    logic        s1_free;
    logic        issue;
    logic        issue_keep;
    t_rgb        pix_color;
    t_rgb        ram_rdata;
    t_rgb        s1_color;
    logic        hit;
    logic [2:0]  hk;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Frame timing and trigger flash decisions.
    assign n_since = r_since + 32'd1;
    assign due = (n_since >= {22'd0, r_frame_interval});
    assign flash = (r_error_flash == 16'd0) ? 16'd1 : r_error_flash;
    assign ind_on = (r_m400 < IND_STEP_1) || ((r_m400 >= IND_STEP_2) && (r_m400 < IND_STEP_3));

    // Phase residues derived from the stored counters.
    assign p24 = (r_p48 >= 6'(RING_SPAN)) ? r_p48 - 6'(RING_SPAN) : r_p48;
    assign p12 = (p24 >= 6'd12) ? p24 - 6'd12 : p24;
    assign p20 = (r_p40 >= 6'd20) ? r_p40 - 6'd20 : r_p40;
    assign start = (r_display_mode == MODE_WAIT_CARD) ? r_p48[5:1] : p24[4:0];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_interval <= FRAME_INTERVAL_RST;
            r_trigger_length <= TRIGGER_LENGTH_RST;
            r_error_flash <= ERROR_FLASH_RST;
            r_ring_layout <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_INTERVAL: r_frame_interval <= i_cfg_data[9:0];
                CFG_TRIGGER_LENGTH: r_trigger_length <= i_cfg_data;
                CFG_ERROR_FLASH: r_error_flash <= i_cfg_data;
                CFG_RING_LAYOUT: r_ring_layout <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Main sequencer: item decode, trigger evaluation, frame setup and pixel sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_since <= '0;
            r_elapsed <= '0;
            r_m400 <= '0;
            r_active <= TRIG_NONE;
            r_saved_mode <= MODE_CONFIG;
            r_display_mode <= MODE_CONFIG;
            r_phase <= '0;
            r_p48 <= '0;
            r_p40 <= '0;
            r_p30 <= '0;
            r_p25 <= '0;
            r_p10 <= '0;
            r_pix <= '0;
            r_kind <= KIND_FILL;
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_func)
                            FUNC_TICK: begin
                                r_since <= due ? 32'd0 : n_since;
                                r_elapsed <= r_elapsed + 32'd1;
                                if (r_elapsed == 32'hFFFF_FFFF
                                        || r_m400 == IND_PERIOD_LAST) begin
                                    r_m400 <= '0;
                                end else begin
                                    r_m400 <= r_m400 + 9'd1;
                                end
                                if (due) begin
                                    r_state <= ST_FRAME;
                                end
                            end
                            FUNC_SET_MODE: begin
                                if (r_active == TRIG_NONE && i_new_mode <= MODE_FW_UPDATE) begin
                                    r_display_mode <= i_new_mode;
                                end
                            end
                            FUNC_SUCCESS, FUNC_ERROR, FUNC_INDICATE: begin
                                r_saved_mode <= r_display_mode;
                                r_active <= 2'(i_func - 3'd1);
                                r_elapsed <= '0;
                                r_m400 <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FRAME: begin
                    if (r_active == TRIG_ERROR) begin
                        r_acc <= {3'd0, flash};
                        r_cnt <= '0;
                        r_state <= ST_ERR;
                    end else if (r_active != TRIG_NONE) begin
                        r_state <= ST_EMIT;
                        if (r_elapsed < {16'd0, r_trigger_length}) begin
                            r_kind <= KIND_FILL;
                            if (r_active == TRIG_SUCCESS) begin
                                r_fill <= RGB_GREEN;
                            end else begin
                                r_fill <= ind_on ? RGB_YELLOW : RGB_OFF;
                            end
                        end else begin
                            r_kind <= KIND_KEEP;
                            r_active <= TRIG_NONE;
                            r_display_mode <= r_saved_mode;
                        end
                    end else if (r_display_mode == MODE_FW_UPDATE) begin
                        r_state <= ST_IDLE;
                    end else begin
                        // Advance the phase and its residues; a full wrap restarts them.
                        r_phase <= r_phase + 32'd1;
                        if (r_phase == 32'hFFFF_FFFF) begin
                            r_p48 <= '0;
                            r_p40 <= '0;
                            r_p30 <= '0;
                            r_p25 <= '0;
                            r_p10 <= '0;
                        end else begin
                            r_p48 <= (r_p48 == 6'd47) ? 6'd0 : r_p48 + 6'd1;
                            r_p40 <= (r_p40 == 6'd39) ? 6'd0 : r_p40 + 6'd1;
                            r_p30 <= (r_p30 == 5'd29) ? 5'd0 : r_p30 + 5'd1;
                            r_p25 <= (r_p25 == 5'd24) ? 5'd0 : r_p25 + 5'd1;
                            r_p10 <= (r_p10 == 4'd9) ? 4'd0 : r_p10 + 4'd1;
                        end
                        r_state <= ST_SETUP;
                    end
                end
                ST_ERR: begin
                    // Count the flash lengths that have fully passed, up to six.
                    if (r_cnt != ERR_PHASES && r_elapsed >= {13'd0, r_acc}) begin
                        r_cnt <= r_cnt + 3'd1;
                        r_acc <= r_acc + {3'd0, flash};
                    end else begin
                        r_state <= ST_EMIT;
                        if (r_cnt == ERR_PHASES) begin
                            r_kind <= KIND_KEEP;
                            r_active <= TRIG_NONE;
                            r_display_mode <= r_saved_mode;
                        end else begin
                            r_kind <= KIND_FILL;
                            r_fill <= r_cnt[0] ? RGB_OFF : RGB_RED;
                        end
                    end
                end
                ST_SETUP: begin
                    r_state <= ST_EMIT;
                    r_len <= (r_display_mode == MODE_WAIT_CARD)
                        ? 4'd4 + {1'b0, p20[4:2]} : 4'd6;
                    for (int k = 0; k < 8; k++) begin
                        r_pos[k] <= WRAP_TBL[start + 5'(k)][IDX_W-1:0];
                    end
                    if (r_ring_layout) begin
                        unique case (r_display_mode)
                            MODE_CONFIG: begin
                                r_kind <= KIND_DOT;
                                r_dot_pos <= p24[4:0];
                                r_dot_col <= RGB_ORANGE;
                            end
                            MODE_INIT: r_kind <= KIND_COMET;
                            MODE_WAIT_CARD: r_kind <= KIND_ARC;
                            MODE_AUTH: begin
                                r_kind <= KIND_DOT;
                                r_dot_pos <= {p12[3:0], 1'b0};
                                r_dot_col <= RGB_CYAN;
                            end
                            MODE_NO_RES: begin
                                r_kind <= (p20 < 6'd10) ? KIND_HALF : KIND_FILL;
                                r_fill <= RGB_OFF;
                            end
                            default: begin
                                r_kind <= KIND_FILL;
                                r_fill <= RGB_OFF;
                            end
                        endcase
                    end else begin
                        r_kind <= KIND_FILL;
                        unique case (r_display_mode)
                            MODE_CONFIG: r_fill <= LIN0_TBL[r_p40];
                            MODE_INIT: r_fill <= LIN1_TBL[r_p30];
                            MODE_WAIT_CARD: r_fill <= LIN2_TBL[r_p25];
                            MODE_AUTH: r_fill <= LIN3_TBL[r_p10];
                            MODE_NO_RES: r_fill <= (p20 < 6'd10) ? RGB_ORANGE : RGB_OFF;
                            default: r_fill <= RGB_OFF;
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (issue) begin
                        if (r_pix == LAST_PIX) begin
                            r_pix <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_pix <= r_pix + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Color of the pixel being issued; later segments of an arc win.
    always_comb begin
        hit = 1'b0;
        hk = '0;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < r_len && r_pos[k] == r_pix) begin
                hit = 1'b1;
                hk = 3'(k);
            end
        end
        unique case (r_kind)
            KIND_FILL: pix_color = r_fill;
            KIND_DOT: pix_color = ({1'b0, r_dot_pos} == 6'(r_pix)) ? r_dot_col : RGB_OFF;
            KIND_HALF: pix_color = (6'(r_pix) < 6'(RING_SPAN)) ? RGB_ORANGE : RGB_OFF;
            KIND_COMET: pix_color = hit ? {16'd0, comet_blue(hk)} : RGB_OFF;
            KIND_ARC: begin
                if (!hit) begin
                    pix_color = RGB_OFF;
                end else if (hk == 3'd0 || {1'b0, hk} == r_len - 4'd1) begin
                    pix_color = {8'd0, 8'd128, 8'd0};
                end else begin
                    pix_color = RGB_GREEN;
                end
            end
            default: pix_color = RGB_OFF;
        endcase
    end

    // Pipeline handshake: issue stage, RAM read stage, output register.
    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_free = !r_s1_valid || out_free;
    assign issue = (r_state == ST_EMIT) && s1_free;
    assign issue_keep = (r_kind == KIND_KEEP);

    sla_ram #(
        .WIDTH(24),
        .DEPTH(LED_COUNT)
    ) u_pixels (
        .i_clk  (i_clk),
        .i_we   (issue && !issue_keep),
        .i_waddr(r_pix),
        .i_wdata(pix_color),
        .i_re   (issue && issue_keep),
        .i_raddr(r_pix),
        .o_rdata(ram_rdata)
    );

    // Valid flags mark pixels that have been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (issue && !issue_keep) begin
            r_valid[r_pix] <= 1'b1;
        end
    end

    // Stage one holds the issued pixel until the output register takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (issue) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_idx <= r_pix;
            r_s1_color <= pix_color;
            r_s1_keep <= issue_keep;
            r_s1_vld <= r_valid[r_pix];
            r_s1_last <= (r_pix == LAST_PIX);
        end
    end

    assign s1_color = r_s1_keep ? (r_s1_vld ? ram_rdata : RGB_OFF) : r_s1_color;

    // Output register of the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_idx <= 6'(r_s1_idx);
            r_out_color <= s1_color;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_red = r_out_color[23:16];
    assign o_green = r_out_color[15:8];
    assign o_blue = r_out_color[7:0];
    assign o_frame_end = r_out_last;

endmodule
